// File: rtl/pdf_pkg.sv
// Shared types, constants and the byte-wide CRC-32 step for the frame deframer.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package pdf_pkg;

	// Frame geometry
	localparam int MAX_FRAME_BYTES = 520;
	localparam int POS_W           = $clog2(MAX_FRAME_BYTES + 2);
	localparam int HDR_BYTES       = 4;
	localparam int CRC_BYTES       = 4;
	localparam int FRAME_OVERHEAD  = HDR_BYTES + CRC_BYTES;
	localparam int LEN_W           = 16;
	localparam int LEN_SUM_W       = LEN_W + 1;

	// CRC-32, zlib form
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAX_PAYLOAD    = 2'd0,
		CFG_MAX_WINDOW     = 2'd1,
		CFG_ACCEPTED_TYPES = 2'd2
	} cfg_idx_t;

	// End-of-frame status codes
	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_LENGTH       = 3'd1,
		ST_NO_PAYLOAD   = 3'd2,
		ST_INCONSISTENT = 3'd3,
		ST_CRC          = 3'd4,
		ST_TYPE         = 3'd5,
		ST_WINDOW       = 3'd6
	} status_t;

	typedef struct packed {
		logic [LEN_W-1:0] max_payload;
		logic [4:0]       max_window;
		logic [7:0]       accepted_types;
	} cfg_t;

	// Everything the status logic and output register need for one word
	typedef struct packed {
		logic             last;
		logic             emit;
		logic [7:0]       data;
		logic [2:0]       ftype;
		logic [4:0]       win;
		logic [7:0]       seq;
		logic [LEN_W-1:0] len;
		logic [POS_W-1:0] count;
		logic [31:0]      crc_calc;
		logic [31:0]      crc_rx;
	} frame_view_t;

	// One byte through the reflected CRC-32
	function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
		logic [31:0] c;
		c = crc_in ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// File: rtl/packet_deframer_crc32_check.sv
// Length-prefixed frame deframer with CRC-32 check: input register, frame logic, result register.
// A word taken into the input register passes through the frame logic into the result register once that can load.
// Throughput: one word per cycle; while a result waits, stage 1 takes one more word, then
// in_ready drops. Reset (arst_n low): frame state cleared, CRC preset to all ones, registers to
// max_payload 512, max_window 31, accepted_types 0x0E. Depends on pdf_pkg and submodules.
`default_nettype none

module packet_deframer_crc32_check (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// configuration write channel
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [pdf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [15:0]                 cfg_data,
	// input word channel
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [7:0]                  frame_byte,
	input  wire logic                        last_byte,
	// result channel
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic                             is_status,
	output logic [7:0]                       payload_byte,
	output logic [2:0]                       status,
	output logic [2:0]                       frame_type,
	output logic [4:0]                       window_size,
	output logic [7:0]                       sequence_number,
	output logic [15:0]                      payload_length,
	output logic [31:0]                      received_crc
);

	pdf_pkg::cfg_t        cfg_q;
	pdf_pkg::frame_view_t view;
	pdf_pkg::status_t     st;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       adv;
	logic       has_result;

	// Configuration registers, always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_payload    <= 16'd512;
			cfg_q.max_window     <= 5'd31;
			cfg_q.accepted_types <= 8'h0E;
		end else if (cfg_valid) begin
			case (pdf_pkg::cfg_idx_t'(cfg_index))
				pdf_pkg::CFG_MAX_PAYLOAD:    cfg_q.max_payload    <= cfg_data;
				pdf_pkg::CFG_MAX_WINDOW:     cfg_q.max_window     <= cfg_data[4:0];
				pdf_pkg::CFG_ACCEPTED_TYPES: cfg_q.accepted_types <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Stage handshake: stage 1 moves whenever the result register can load
	assign adv      = !out_valid || out_ready;
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= frame_byte;
			last_s1 <= last_byte;
		end
	end

	pdf_frame_track u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (valid_s1 && adv),
		.data   (byte_s1),
		.last   (last_s1),
		.view   (view)
	);

	pdf_status_eval u_eval (
		.view   (view),
		.cfg    (cfg_q),
		.status (st)
	);

	assign has_result = view.emit || view.last;

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= valid_s1 && has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1 && has_result) begin
			is_status <= view.last;
			if (view.last) begin
				payload_byte    <= '0;
				status          <= st;
				frame_type      <= view.ftype;
				window_size     <= view.win;
				sequence_number <= view.seq;
				payload_length  <= view.len;
				received_crc    <= view.crc_rx;
			end else begin
				payload_byte    <= view.data;
				status          <= '0;
				frame_type      <= '0;
				window_size     <= '0;
				sequence_number <= '0;
				payload_length  <= '0;
				received_crc    <= '0;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/pdf_frame_track.sv
// Per-frame state: byte counter, header capture, tail delay line and running CRC.
// Depends on pdf_pkg.
`default_nettype none

module pdf_frame_track (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 step,
	input  wire logic [7:0]           data,
	input  wire logic                 last,
	output pdf_pkg::frame_view_t      view
);

	localparam logic [pdf_pkg::POS_W-1:0] POS_SAT =
		pdf_pkg::POS_W'(pdf_pkg::MAX_FRAME_BYTES + 1);
	localparam logic [pdf_pkg::POS_W-1:0] POS_MAX =
		pdf_pkg::POS_W'(pdf_pkg::MAX_FRAME_BYTES);
	localparam logic [pdf_pkg::POS_W-1:0] POS_HDR =
		pdf_pkg::POS_W'(pdf_pkg::HDR_BYTES);

	logic [pdf_pkg::POS_W-1:0] pos_q, pos_n;
	logic [7:0]                hdr_q, hdr_n;
	logic [7:0]                seq_q, seq_n;
	logic [pdf_pkg::LEN_W-1:0] len_q, len_n;
	logic [31:0]               crc_q, crc_n;
	logic [7:0]                tail_q [pdf_pkg::CRC_BYTES];
	logic                      in_body;
	logic [pdf_pkg::LEN_SUM_W-1:0] pay_end;

	// Header capture, counter and CRC update; the CRC takes the oldest tail byte, not the current word
	always_comb begin
		hdr_n = (pos_q == pdf_pkg::POS_W'(0)) ? data : hdr_q;
		seq_n = (pos_q == pdf_pkg::POS_W'(1)) ? data : seq_q;
		len_n = len_q;
		if (pos_q == pdf_pkg::POS_W'(2)) begin
			len_n = {data, len_q[7:0]};
		end else if (pos_q == pdf_pkg::POS_W'(3)) begin
			len_n = {len_q[15:8], data};
		end
		in_body = (pos_q >= POS_HDR);
		crc_n   = in_body ? pdf_pkg::crc_byte(crc_q, tail_q[0]) : crc_q;
		pos_n   = (pos_q < POS_SAT) ? pos_q + pdf_pkg::POS_W'(1) : pos_q;
		pay_end = {1'b0, len_n} + pdf_pkg::LEN_SUM_W'(pdf_pkg::HDR_BYTES);
	end

	// View handed to the status logic and output stage
	always_comb begin
		view.last     = last;
		view.emit     = !last && in_body && (pdf_pkg::LEN_SUM_W'(pos_q) < pay_end)
			&& (pos_q < POS_MAX);
		view.data     = data;
		view.ftype    = hdr_n[7:5];
		view.win      = hdr_n[4:0];
		view.seq      = seq_n;
		view.len      = len_n;
		view.count    = pos_n;
		view.crc_calc = crc_n ^ pdf_pkg::CRC_INIT;
		view.crc_rx   = {tail_q[1], tail_q[2], tail_q[3], data};
	end

	// State update; a last byte returns the frame state to reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			hdr_q <= '0;
			seq_q <= '0;
			len_q <= '0;
			crc_q <= pdf_pkg::CRC_INIT;
			for (int i = 0; i < pdf_pkg::CRC_BYTES; i++) begin
				tail_q[i] <= '0;
			end
		end else if (step) begin
			if (last) begin
				pos_q <= '0;
				hdr_q <= '0;
				seq_q <= '0;
				len_q <= '0;
				crc_q <= pdf_pkg::CRC_INIT;
				for (int i = 0; i < pdf_pkg::CRC_BYTES; i++) begin
					tail_q[i] <= '0;
				end
			end else begin
				pos_q <= pos_n;
				hdr_q <= hdr_n;
				seq_q <= seq_n;
				len_q <= len_n;
				crc_q <= crc_n;
				for (int i = 0; i < pdf_pkg::CRC_BYTES - 1; i++) begin
					tail_q[i] <= tail_q[i+1];
				end
				tail_q[pdf_pkg::CRC_BYTES-1] <= data;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/pdf_status_eval.sv
// End-of-frame checks in priority order, giving the status code.
// Depends on pdf_pkg.
`default_nettype none

module pdf_status_eval (
	input  wire pdf_pkg::frame_view_t view,
	input  wire pdf_pkg::cfg_t        cfg,
	output pdf_pkg::status_t          status
);

	logic [1:0]                    pad;
	logic [pdf_pkg::LEN_SUM_W-1:0] expect_n;
	logic                          len_err;
	logic                          no_pay;
	logic                          incons;

	always_comb begin
		// pad up to a multiple of four
		pad      = (~view.len[1:0]) + 2'd1;
		expect_n = pdf_pkg::LEN_SUM_W'(pdf_pkg::FRAME_OVERHEAD) + {1'b0, view.len}
			+ {{(pdf_pkg::LEN_SUM_W-2){1'b0}}, pad};
		len_err  = (view.len > cfg.max_payload)
			|| (view.count > pdf_pkg::POS_W'(pdf_pkg::MAX_FRAME_BYTES));
		no_pay   = (view.count == pdf_pkg::POS_W'(pdf_pkg::FRAME_OVERHEAD));
		incons   = (expect_n != pdf_pkg::LEN_SUM_W'(view.count));

		if (len_err) begin
			status = pdf_pkg::ST_LENGTH;
		end else if (no_pay) begin
			status = pdf_pkg::ST_NO_PAYLOAD;
		end else if (incons) begin
			status = pdf_pkg::ST_INCONSISTENT;
		end else if (view.crc_calc != view.crc_rx) begin
			status = pdf_pkg::ST_CRC;
		end else if (!cfg.accepted_types[view.ftype]) begin
			status = pdf_pkg::ST_TYPE;
		end else if (view.win > cfg.max_window) begin
			status = pdf_pkg::ST_WINDOW;
		end else begin
			status = pdf_pkg::ST_OK;
		end
	end

endmodule

`default_nettype wire

// File: bench/packet_deframer_crc32_check_test.sv
// Self-checking bench for packet_deframer_crc32_check: directed frames, then random frame traffic
// under several register settings, every output word scored against an in-bench deframer model.
// Depends on pdf_pkg and the RTL top level only.

module packet_deframer_crc32_check_test;

	// Bench-local codes for the kinds of random frame
	typedef enum int {
		FR_GOOD,
		FR_BAD_CRC,
		FR_BAD_SIZE,
		FR_NOISE,
		FR_BIG_LEN
	} frame_kind_t;

	// One output word, laid out like the result ports
	typedef struct packed {
		logic        is_status;
		logic [7:0]  payload_byte;
		logic [2:0]  status;
		logic [2:0]  frame_type;
		logic [4:0]  window_size;
		logic [7:0]  sequence_number;
		logic [15:0] payload_length;
		logic [31:0] received_crc;
	} frame_word_t;

	// Directed row: crc_sel 1..4 picks a byte of the frame CRC, big-endian
	typedef struct {
		logic [7:0]       val;
		bit               last;
		int               crc_sel;
		bit               typed;
		pdf_pkg::status_t want;
	} probe_row_t;

	localparam int NUM_PROBES = 25;
	localparam int NUM_PHASES = 7;
	localparam int PHASE_ITEMS = 232;
	localparam int SQUEEZE_CYCLES = 400;
	localparam logic [31:0] CRC32_REFLECTED = 32'hEDB8_8320;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [pdf_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [15:0]                   cfg_data;
	logic                          in_valid;
	logic                          in_ready;
	logic [7:0]                    frame_byte;
	logic                          last_byte;
	logic                          out_valid;
	logic                          out_ready;
	logic                          is_status;
	logic [7:0]                    payload_byte;
	logic [2:0]                    status;
	logic [2:0]                    frame_type;
	logic [4:0]                    window_size;
	logic [7:0]                    sequence_number;
	logic [15:0]                   payload_length;
	logic [31:0]                   received_crc;

	packet_deframer_crc32_check dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.frame_byte      (frame_byte),
		.last_byte       (last_byte),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.is_status       (is_status),
		.payload_byte    (payload_byte),
		.status          (status),
		.frame_type      (frame_type),
		.window_size     (window_size),
		.sequence_number (sequence_number),
		.payload_length  (payload_length),
		.received_crc    (received_crc)
	);

	// Model copy of the registers
	logic [15:0] lim_payload;
	logic [4:0]  lim_window;
	logic [7:0]  type_mask;

	// Model copy of the frame state
	int          fr_pos;
	logic [7:0]  fr_hdr;
	logic [7:0]  fr_seq;
	logic [15:0] fr_len;
	logic [31:0] fr_crc;
	logic [7:0]  fr_tail [4];

	frame_word_t awaited_words [$];
	logic [7:0]  frame_bytes [$];
	probe_row_t  probe_rows [NUM_PROBES];

	int fail_count;
	int items_sent;
	int send_mode;
	bit squeeze_req;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3000000;
		$display("Regression FAIL");
		$finish;
	end

	// Bitwise reflected CRC-32 update, one data bit per pass
	function automatic logic [31:0] crc32_advance(logic [31:0] acc, logic [7:0] d);
		logic [31:0] r;
		int i;
		r = acc;
		for (i = 0; i < 8; i++) begin
			r = (r >> 1) ^ ({32{r[0] ^ d[i]}} & CRC32_REFLECTED);
		end
		return r;
	endfunction

	function automatic void frame_restart();
		fr_pos = 0;
		fr_hdr = '0;
		fr_seq = '0;
		fr_len = '0;
		fr_crc = '1;
		for (int i = 0; i < 4; i++) fr_tail[i] = '0;
	endfunction

	// Deframer model: one accepted byte in, zero or one expected word queued
	function automatic void deframe_byte(logic [7:0] b, logic l);
		int idx;
		int pad;
		logic [31:0] rx;
		logic [31:0] calc;
		logic [2:0] ft;
		frame_word_t w;
		pdf_pkg::status_t st;
		idx = fr_pos;
		w = '0;
		case (idx)
			0: fr_hdr = b;
			1: fr_seq = b;
			2: fr_len[15:8] = b;
			3: fr_len[7:0] = b;
			default: ;
		endcase
		// tail bytes stay out of the CRC until four newer ones follow
		if (idx >= 4) fr_crc = crc32_advance(fr_crc, fr_tail[0]);
		fr_tail[0] = fr_tail[1];
		fr_tail[1] = fr_tail[2];
		fr_tail[2] = fr_tail[3];
		fr_tail[3] = b;
		if (fr_pos < pdf_pkg::MAX_FRAME_BYTES + 1) fr_pos++;
		if (!l) begin
			if (idx >= 4 && idx < 4 + int'(fr_len) && idx < pdf_pkg::MAX_FRAME_BYTES) begin
				w.payload_byte = b;
				awaited_words.push_back(w);
			end
		end else begin
			pad = (4 - int'(fr_len[1:0])) % 4;
			rx = {fr_tail[0], fr_tail[1], fr_tail[2], fr_tail[3]};
			calc = ~fr_crc;
			ft = fr_hdr[7:5];
			if (fr_len > lim_payload || fr_pos > pdf_pkg::MAX_FRAME_BYTES)
				st = pdf_pkg::ST_LENGTH;
			else if (fr_pos == pdf_pkg::FRAME_OVERHEAD) st = pdf_pkg::ST_NO_PAYLOAD;
			else if (pdf_pkg::FRAME_OVERHEAD + int'(fr_len) + pad != fr_pos)
				st = pdf_pkg::ST_INCONSISTENT;
			else if (calc != rx) st = pdf_pkg::ST_CRC;
			else if (!type_mask[ft]) st = pdf_pkg::ST_TYPE;
			else if (fr_hdr[4:0] > lim_window) st = pdf_pkg::ST_WINDOW;
			else st = pdf_pkg::ST_OK;
			w.is_status = 1'b1;
			w.status = st;
			w.frame_type = ft;
			w.window_size = fr_hdr[4:0];
			w.sequence_number = fr_seq;
			w.payload_length = fr_len;
			w.received_crc = rx;
			awaited_words.push_back(w);
			frame_restart();
		end
	endfunction

	// Idle cycles before one word: none, full range, or mostly none
	function automatic int pick_wait(int mode);
		if (mode == 0) return 0;
		if (mode == 1) return $urandom_range(0, 13);
		return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 13) : 0;
	endfunction

	function automatic string word_text(frame_word_t w);
		return $sformatf("stat=%0b byte=%h code=%0d type=%0d win=%0d seq=%h len=%h crc=%h",
			w.is_status, w.payload_byte, w.status, w.frame_type, w.window_size,
			w.sequence_number, w.payload_length, w.received_crc);
	endfunction

	// Offer one input word, hold it until taken, then run the model
	task automatic push_word(logic [7:0] b, logic l);
		int gap;
		if (items_sent % 40 == 0) send_mode = $urandom_range(0, 2);
		gap = pick_wait(send_mode);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		frame_byte <= b;
		last_byte <= l;
		do @(posedge clk); while (!in_ready);
		deframe_byte(b, l);
		items_sent++;
	endtask

	task automatic write_reg(pdf_pkg::cfg_idx_t idx, logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			pdf_pkg::CFG_MAX_PAYLOAD: lim_payload = val;
			pdf_pkg::CFG_MAX_WINDOW: lim_window = val[4:0];
			pdf_pkg::CFG_ACCEPTED_TYPES: type_mask = val[7:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Drop valid, let every expected word come out, then idle before returning
	task automatic quiesce();
		@(negedge clk);
		in_valid <= 1'b0;
		while (awaited_words.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	// Assemble one frame into frame_bytes
	function automatic void build_frame(frame_kind_t kind, int len);
		int body;
		int k;
		logic [31:0] acc;
		logic [15:0] lenf;
		frame_bytes.delete();
		if (kind == FR_NOISE) begin
			k = $urandom_range(1, 24);
			repeat (k) frame_bytes.push_back(8'($urandom_range(0, 255)));
		end else begin
			lenf = len[15:0];
			body = len + (4 - len % 4) % 4;
			if (kind == FR_BIG_LEN) begin
				lenf = 16'($urandom_range(0, 65535));
				body = $urandom_range(0, 8);
			end else if (kind == FR_BAD_SIZE) begin
				if (body > 0 && $urandom_range(0, 1) == 1) body -= $urandom_range(1, body);
				else body += $urandom_range(1, 5);
			end
			frame_bytes.push_back(8'($urandom_range(0, 255)));
			frame_bytes.push_back(8'($urandom_range(0, 255)));
			frame_bytes.push_back(lenf[15:8]);
			frame_bytes.push_back(lenf[7:0]);
			repeat (body) frame_bytes.push_back(8'($urandom_range(0, 255)));
			acc = '1;
			foreach (frame_bytes[i]) acc = crc32_advance(acc, frame_bytes[i]);
			acc = ~acc;
			frame_bytes.push_back(acc[31:24]);
			frame_bytes.push_back(acc[23:16]);
			frame_bytes.push_back(acc[15:8]);
			frame_bytes.push_back(acc[7:0]);
			// one flipped bit past the header
			if (kind == FR_BAD_CRC) begin
				k = $urandom_range(4, frame_bytes.size() - 1);
				frame_bytes[k] = frame_bytes[k] ^ 8'(1 << $urandom_range(0, 7));
			end
		end
	endfunction

	task automatic send_frame();
		foreach (frame_bytes[i]) push_word(frame_bytes[i], i == frame_bytes.size() - 1);
	endtask

	// Receiver: random back-pressure, one long hold on request, scoring
	initial begin : drain
		int stall;
		int mode;
		int seen;
		bit squeezed;
		frame_word_t got;
		frame_word_t want;
		out_ready = 1'b0;
		seen = 0;
		mode = 0;
		squeezed = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (seen % 40 == 0) mode = $urandom_range(0, 2);
			stall = pick_wait(mode);
			if (squeeze_req && !squeezed) begin
				stall = SQUEEZE_CYCLES;
				squeezed = 1'b1;
			end
			@(negedge clk);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			got = {is_status, payload_byte, status, frame_type, window_size,
				sequence_number, payload_length, received_crc};
			seen++;
			if (awaited_words.size() == 0) begin
				fail_count++;
				if (fail_count <= 10) $display("%0t unexpected word: %s", $realtime, word_text(got));
			end else begin
				want = awaited_words.pop_front();
				if (got !== want) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("%0t word mismatch\n  exp %s\n  got %s", $realtime,
							word_text(want), word_text(got));
					end
				end
			end
		end
	end

	// Stimulus: reset, directed rows, then phased random frames
	initial begin : stim
		logic [31:0] probe_crc;
		logic [31:0] fin;
		logic [7:0] val;
		int p;
		int frames;
		int len;
		int r;
		frame_kind_t kind;
		arst_n = 1'b0;
		in_valid = 1'b0;
		frame_byte = '0;
		last_byte = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = pdf_pkg::CFG_MAX_PAYLOAD;
		cfg_data = '0;
		fail_count = 0;
		items_sent = 0;
		send_mode = 0;
		squeeze_req = 1'b0;
		lim_payload = 16'd512;
		lim_window = 5'd31;
		type_mask = 8'h0E;
		frame_restart();

		probe_rows = '{
			// lone header byte that is also the last: short frame
			'{8'hFF, 1'b1, 0, 1'b1, pdf_pkg::ST_INCONSISTENT},
			// header plus four tail bytes, no payload
			'{8'h20, 1'b0, 0, 1'b0, pdf_pkg::ST_OK},
			'{8'h00, 1'b0, 0, 1'b0, pdf_pkg::ST_OK},
			'{8'h00, 1'b0, 0, 1'b0, pdf_pkg::ST_OK},
			'{8'h00, 1'b0, 0, 1'b0, pdf_pkg::ST_OK},
			'{8'hDE, 1'b0, 0, 1'b0, pdf_pkg::ST_OK},
			'{8'hAD, 1'b0, 0, 1'b0, pdf_pkg::ST_OK},
			'{8'hBE, 1'b0, 0, 1'b0, pdf_pkg::ST_OK},
			'{8'hEF, 1'b1, 0, 1'b1, pdf_pkg::ST_NO_PAYLOAD},
			// one payload byte, three pad bytes, correct CRC
			'{8'h21, 1'b0, 0, 1'b0, pdf_pkg::ST_OK},
			'{8'hA5, 1'b0, 0, 1'b0, pdf_pkg::ST_OK},
			'{8'h00, 1'b0, 0, 1'b0, pdf_pkg::ST_OK},
			'{8'h01, 1'b0, 0, 1'b0, pdf_pkg::ST_OK},
			'{8'hFF, 1'b0, 0, 1'b0, pdf_pkg::ST_OK},
			'{8'h00, 1'b0, 0, 1'b0, pdf_pkg::ST_OK},
			'{8'h00, 1'b0, 0, 1'b0, pdf_pkg::ST_OK},
			'{8'h00, 1'b0, 0, 1'b0, pdf_pkg::ST_OK},
			'{8'h00, 1'b0, 1, 1'b0, pdf_pkg::ST_OK},
			'{8'h00, 1'b0, 2, 1'b0, pdf_pkg::ST_OK},
			'{8'h00, 1'b0, 3, 1'b0, pdf_pkg::ST_OK},
			'{8'h00, 1'b1, 4, 1'b1, pdf_pkg::ST_OK},
			// short frame carrying the largest length field
			'{8'h00, 1'b0, 0, 1'b0, pdf_pkg::ST_OK},
			'{8'h00, 1'b0, 0, 1'b0, pdf_pkg::ST_OK},
			'{8'hFF, 1'b0, 0, 1'b0, pdf_pkg::ST_OK},
			'{8'hFF, 1'b1, 0, 1'b1, pdf_pkg::ST_LENGTH}
		};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed rows
		probe_crc = '1;
		for (int i = 0; i < NUM_PROBES; i++) begin
			if (probe_rows[i].crc_sel == 0) begin
				val = probe_rows[i].val;
				probe_crc = crc32_advance(probe_crc, val);
			end else begin
				fin = ~probe_crc;
				val = 8'(fin >> (8 * (4 - probe_rows[i].crc_sel)));
			end
			push_word(val, probe_rows[i].last);
			if (probe_rows[i].typed) awaited_words[awaited_words.size() - 1].status = probe_rows[i].want;
			if (probe_rows[i].last) probe_crc = '1;
		end

		// Random phases, registers rewritten only while idle
		for (p = 0; p < NUM_PHASES; p++) begin
			if (p > 0) begin
				quiesce();
				case (p)
					1: begin
						write_reg(pdf_pkg::CFG_MAX_PAYLOAD, 16'hFFFF);
						write_reg(pdf_pkg::CFG_MAX_WINDOW, 16'd31);
						write_reg(pdf_pkg::CFG_ACCEPTED_TYPES, 16'h00FF);
					end
					2: begin
						write_reg(pdf_pkg::CFG_ACCEPTED_TYPES, 16'h0000);
						write_reg(pdf_pkg::CFG_MAX_WINDOW, 16'd0);
						write_reg(pdf_pkg::CFG_MAX_PAYLOAD, 16'd0);
					end
					3: begin
						write_reg(pdf_pkg::CFG_MAX_PAYLOAD, 16'd512);
						write_reg(pdf_pkg::CFG_MAX_WINDOW, 16'($urandom_range(0, 31)));
						write_reg(pdf_pkg::CFG_ACCEPTED_TYPES, 16'($urandom_range(0, 255)));
					end
					default: begin
						r = $urandom_range(0, 2);
						write_reg(pdf_pkg::CFG_MAX_PAYLOAD,
							(r == 0) ? 16'($urandom_range(0, 24)) :
							(r == 1) ? 16'd512 : 16'hFFFF);
						// upper data bits are random; only the register width counts
						write_reg(pdf_pkg::CFG_MAX_WINDOW, 16'($urandom_range(0, 65535)));
						write_reg(pdf_pkg::CFG_ACCEPTED_TYPES, 16'($urandom_range(0, 65535)));
					end
				endcase
			end
			// long receiver hold while frames keep coming
			if (p == 3) squeeze_req = 1'b1;
			// largest legal frame, then one past the frame limit
			if (p == 1) begin
				build_frame(FR_GOOD, 512);
				send_frame();
				build_frame(FR_GOOD, 513);
				send_frame();
			end
			frames = 0;
			while (frames < 3 || items_sent < NUM_PROBES + (p + 1) * PHASE_ITEMS) begin
				r = $urandom_range(0, 99);
				if (r < 60) kind = FR_GOOD;
				else if (r < 72) kind = FR_BAD_CRC;
				else if (r < 84) kind = FR_BAD_SIZE;
				else if (r < 92) kind = FR_NOISE;
				else kind = FR_BIG_LEN;
				len = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
				build_frame(kind, len);
				send_frame();
				frames++;
			end
		end

		quiesce();
		fail_count += awaited_words.size();
		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
